/* sv/sgr_pkg.sv */
// ----------------------------------------------------------------------------
// sgr_pkg
// types, constants and the 5x7 font table shared by the glyph row rasterizer
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int GLYPH_W    = 5;
  localparam int GLYPH_H    = 7;
  localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;
  localparam int MASK_W     = 40;
  localparam int HW_SCALE_CAP = 8;

  // font index codes
  localparam logic [5:0] IDX_DIGIT0 = 6'd26;
  localparam logic [5:0] IDX_BANG   = 6'd36;
  localparam logic [5:0] IDX_DASH   = 6'd37;
  localparam logic [5:0] IDX_DOT    = 6'd38;
  localparam logic [5:0] IDX_COLON  = 6'd39;
  localparam logic [5:0] IDX_BLANK  = 6'd40;

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ROWS
  } state_t;

  // selects one pixel line of the latched glyph
  typedef struct packed {
    logic [2:0] gy;     // font line
    logic [3:0] scale;  // magnification
  } row_sel_t;

  // column c in bits 7c..7c+6, bit 0 of each column is the top line
  function automatic glyph_t pack5(input logic [7:0] c0, input logic [7:0] c1,
                                   input logic [7:0] c2, input logic [7:0] c3,
                                   input logic [7:0] c4);
    return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  // folds lower case and maps a character code onto a font entry
  function automatic logic [5:0] char_to_index(input logic [7:0] code);
    logic [5:0] idx;
    idx = IDX_BLANK;
    if (code >= 8'h61 && code <= 8'h7a) begin
      idx = 6'(code - 8'h61);
    end else if (code >= 8'h41 && code <= 8'h5a) begin
      idx = 6'(code - 8'h41);
    end else if (code >= 8'h30 && code <= 8'h39) begin
      idx = IDX_DIGIT0 + 6'(code - 8'h30);
    end else if (code == 8'h21) begin
      idx = IDX_BANG;
    end else if (code == 8'h2d) begin
      idx = IDX_DASH;
    end else if (code == 8'h2e) begin
      idx = IDX_DOT;
    end else if (code == 8'h3a) begin
      idx = IDX_COLON;
    end
    return idx;
  endfunction

  function automatic glyph_t font_glyph(input logic [5:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = pack5(8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e);
      6'd1:  g = pack5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd2:  g = pack5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h22);
      6'd3:  g = pack5(8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c);
      6'd4:  g = pack5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h41);
      6'd5:  g = pack5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h01);
      6'd6:  g = pack5(8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a);
      6'd7:  g = pack5(8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f);
      6'd8:  g = pack5(8'h00, 8'h41, 8'h7f, 8'h41, 8'h00);
      6'd9:  g = pack5(8'h20, 8'h40, 8'h41, 8'h3f, 8'h01);
      6'd10: g = pack5(8'h7f, 8'h08, 8'h14, 8'h22, 8'h41);
      6'd11: g = pack5(8'h7f, 8'h40, 8'h40, 8'h40, 8'h40);
      6'd12: g = pack5(8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f);
      6'd13: g = pack5(8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f);
      6'd14: g = pack5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e);
      6'd15: g = pack5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h06);
      6'd16: g = pack5(8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e);
      6'd17: g = pack5(8'h7f, 8'h09, 8'h19, 8'h29, 8'h46);
      6'd18: g = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      6'd19: g = pack5(8'h01, 8'h01, 8'h7f, 8'h01, 8'h01);
      6'd20: g = pack5(8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f);
      6'd21: g = pack5(8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f);
      6'd22: g = pack5(8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f);
      6'd23: g = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      6'd24: g = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      6'd25: g = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      6'd26: g = pack5(8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e);
      6'd27: g = pack5(8'h00, 8'h42, 8'h7f, 8'h40, 8'h00);
      6'd28: g = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      6'd29: g = pack5(8'h21, 8'h41, 8'h45, 8'h4b, 8'h31);
      6'd30: g = pack5(8'h18, 8'h14, 8'h12, 8'h7f, 8'h10);
      6'd31: g = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      6'd32: g = pack5(8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30);
      6'd33: g = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      6'd34: g = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd35: g = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1e);
      IDX_BANG:  g = pack5(8'h00, 8'h00, 8'h5f, 8'h00, 8'h00);
      IDX_DASH:  g = pack5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      IDX_DOT:   g = pack5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      IDX_COLON: g = pack5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      default:   g = '0;
    endcase
    return g;
  endfunction

endpackage

/* sv/scaled_glyph_row_rasterizer.sv */
// ----------------------------------------------------------------------------
// scaled_glyph_row_rasterizer
// draws one 5x7 font character at an integer scale as a run of pixel rows
// ----------------------------------------------------------------------------
// One request on the slave side names a character, two colors, a scale and a
// cell position. The block looks the glyph up in a synchronous font rom with a
// registered read and then sends 7*scale rows on the master side, one per pixel
// line, each with a 5*scale bit foreground mask, both colors, the x start and
// the y line; tlast marks the final row. Scale 0 is drawn as 1 and scales above
// min(MAX_SCALE, 8) are clipped to that limit; codes outside the font draw a
// blank cell. The request is taken in the idle state and the rom is read in
// the fetch state; the rows then leave the output register at one row per
// cycle unless the master side stalls. The next request is taken once the last
// row is in the output register, even while that row still waits.
// ----------------------------------------------------------------------------
module scaled_glyph_row_rasterizer
  import sgr_pkg::*;
#(
  parameter int MAX_SCALE = 8
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], fg_color[23:8], bg_color[39:24], scale_factor[43:40],
  // x_start[52:44], y_start[61:53], zero fill above
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_x[8:0], out_y[18:9], pixel_mask[58:19], out_fg[74:59],
  // out_bg[90:75], zero fill above
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_row
);

  // effective scale limit, never below one
  localparam int CAP_RAW = (MAX_SCALE < HW_SCALE_CAP) ? MAX_SCALE : HW_SCALE_CAP;
  localparam logic [3:0] SCALE_CAP = 4'((CAP_RAW < 1) ? 1 : CAP_RAW);

  state_t state, state_next;

  // request fields
  logic [7:0]  in_code;
  logic [15:0] in_fg;
  logic [15:0] in_bg;
  logic [3:0]  in_scale;
  logic [8:0]  in_x;
  logic [8:0]  in_y;
  logic [3:0]  scale_sat;

  // latched character
  logic [15:0] held_fg;
  logic [15:0] held_bg;
  logic [3:0]  held_scale;
  logic [8:0]  held_x;
  logic [8:0]  held_y;

  // row position: row number, font line and sub-line inside a font line
  logic [5:0]  row;
  logic [2:0]  gy;
  logic [3:0]  ysub;

  glyph_t             glyph;
  row_sel_t           sel;
  logic [MASK_W-1:0]  row_mask;

  logic        accept;
  logic        out_free;
  logic        emit;
  logic        is_last;
  logic [9:0]  row_y;

  // output register
  logic        out_valid;
  logic [90:0] out_data;
  logic        out_last;

  assign in_code  = s_axis_tdata[7:0];
  assign in_fg    = s_axis_tdata[23:8];
  assign in_bg    = s_axis_tdata[39:24];
  assign in_scale = s_axis_tdata[43:40];
  assign in_x     = s_axis_tdata[52:44];
  assign in_y     = s_axis_tdata[61:53];

  // clamp into 1..SCALE_CAP
  always_comb begin
    if (in_scale == 4'd0) begin
      scale_sat = 4'd1;
    end else if (in_scale > SCALE_CAP) begin
      scale_sat = SCALE_CAP;
    end else begin
      scale_sat = in_scale;
    end
  end

  // glyph read on request, data valid in the fetch cycle onward
  sgr_font_rom u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (char_to_index(in_code)),
    .rd_data (glyph)
  );

  assign sel.gy    = gy;
  assign sel.scale = held_scale;

  sgr_row_gen u_row (
    .glyph (glyph),
    .sel   (sel),
    .mask  (row_mask)
  );

  // no request is taken while in reset
  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign emit          = (state == ST_ROWS) && out_free;
  assign is_last       = (gy == 3'(GLYPH_H - 1)) && (ysub == held_scale - 4'd1);
  assign row_y         = {1'b0, held_y} + {4'b0, row};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_ROWS;
      end
      ST_ROWS: begin
        if (emit && is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // latch the character and step through its rows
  always_ff @(posedge clk) begin
    if (accept) begin
      held_fg    <= in_fg;
      held_bg    <= in_bg;
      held_scale <= scale_sat;
      held_x     <= in_x;
      held_y     <= in_y;
      row        <= '0;
      gy         <= '0;
      ysub       <= '0;
    end else if (emit) begin
      row <= row + 6'd1;
      if (ysub == held_scale - 4'd1) begin
        ysub <= '0;
        gy   <= gy + 3'd1;
      end else begin
        ysub <= ysub + 4'd1;
      end
    end
  end

  // output register, refilled while rows remain and it is empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= {held_bg, held_fg, row_mask, row_y, held_x};
      out_last <= is_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_data};
  assign m_axis_tlast  = out_last;

  // a request always goes to the rom read cycle
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_FETCH))
    else $error("request not followed by font read");

  // row position stays inside the scaled glyph
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROWS) |-> (gy < 3'(GLYPH_H)) && (ysub < held_scale) && (row < 6'd56))
    else $error("row position out of range");

  // the final row ends the character and marks tlast
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> (state == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
    else $error("final row not flagged");

endmodule

/* sv/sgr_font_rom.sv */
// ----------------------------------------------------------------------------
// sgr_font_rom
// synchronous font rom, one glyph read per cycle with registered data
// ----------------------------------------------------------------------------
module sgr_font_rom
  import sgr_pkg::*;
(
  input  logic       clk,
  input  logic       rd_en,
  input  logic [5:0] rd_idx,
  output glyph_t     rd_data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= font_glyph(rd_idx);
    end
  end

endmodule

/* sv/sgr_row_gen.sv */
// ----------------------------------------------------------------------------
// sgr_row_gen
// expands one font line of a glyph into a scaled pixel mask
// ----------------------------------------------------------------------------
module sgr_row_gen
  import sgr_pkg::*;
(
  input  glyph_t              glyph,
  input  row_sel_t            sel,
  output logic [MASK_W-1:0]   mask
);

  logic [GLYPH_W-1:0] pattern;
  logic [MASK_W-1:0]  block;

  // one bit per font column for the selected line
  always_comb begin
    for (int c = 0; c < GLYPH_W; c++) begin
      pattern[c] = glyph[c*GLYPH_H + int'(sel.gy)];
    end
  end

  // run of scale ones, placed at column*scale for each lit column
  assign block = (MASK_W'(1) << sel.scale) - MASK_W'(1);

  always_comb begin
    mask = '0;
    for (int c = 0; c < GLYPH_W; c++) begin
      if (pattern[c]) begin
        mask = mask | (block << (6'(c) * 6'(sel.scale)));
      end
    end
  end

endmodule
